[rtl/core/ceq_pkg.sv]
// Package for the coalescing event queue: sizes, entry struct, operation and merge codes.
// Has no dependencies; every module of the block imports it.
`default_nettype none
package ceq_pkg;

  localparam int QueueDepth = 16;
  localparam int CountW     = $clog2(QueueDepth + 1);
  localparam int TypeW      = 8;
  localparam int ValueW     = 32;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 9;

  typedef struct packed {
    logic [TypeW-1:0]         etype;
    logic signed [ValueW-1:0] value;
    logic                     flag;
  } entry_t;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    MERGE_MAX  = 2'd0,
    MERGE_SEED = 2'd1,
    MERGE_ACC  = 2'd2,
    MERGE_KEEP = 2'd3
  } merge_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TYPE_COUNT  = 3'd0,
    CFG_MAX_LIMIT   = 3'd1,
    CFG_FLOOR_TYPE  = 3'd2,
    CFG_SEED_TYPE   = 3'd3,
    CFG_ACCUM_TYPE  = 3'd4
  } cfg_idx_e;

endpackage
`default_nettype wire

[rtl/core/ceq_cell.sv]
// One storage cell of the queue chain: holds an entry and takes the one at its next input on shift.
// Depends on ceq_pkg for the entry struct.
`default_nettype none
module ceq_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  ceq_pkg::entry_t next_i,
  output ceq_pkg::entry_t entry_o
);
  import ceq_pkg::*;

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= next_i;
    end
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

[rtl/core/ceq_merge.sv]
// Shared merge unit at the wrap point of the chain: combines a stored value with an incoming one.
// Depends on ceq_pkg for widths and merge codes.
`default_nettype none
module ceq_merge (
  input  ceq_pkg::merge_mode_e               mode_i,
  input  logic signed [ceq_pkg::ValueW-1:0]  stored_i,
  input  logic signed [ceq_pkg::ValueW-1:0]  incoming_i,
  output logic signed [ceq_pkg::ValueW-1:0]  merged_o
);
  import ceq_pkg::*;

  localparam logic signed [ValueW:0] SumMax = {2'b00, {(ValueW-1){1'b1}}};

  logic signed [ValueW-1:0] inc;
  logic signed [ValueW:0]   sum;

  always_comb begin
    inc = (incoming_i > ValueW'(1)) ? incoming_i : ValueW'(1);
    sum = {stored_i[ValueW-1], stored_i} + {inc[ValueW-1], inc};
    case (mode_i)
      MERGE_MAX:  merged_o = (stored_i > incoming_i) ? stored_i : incoming_i;
      MERGE_SEED: merged_o = (stored_i <= ValueW'(0) || incoming_i < stored_i) ?
                             incoming_i : stored_i;
      MERGE_ACC:  merged_o = (sum > SumMax) ? SumMax[ValueW-1:0] : sum[ValueW-1:0];
      default:    merged_o = stored_i;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/coalescing_event_queue.sv]
// Top level of the coalescing event queue: control, configuration and the chain of cells.
// Depends on ceq_pkg, ceq_cell and ceq_merge.
//
//   channel | signals                                   | direction
//   in      | in_valid_i/in_ready_o, func, type, value  | transfer in
//   out     | out_valid_o/out_ready_i, head, count      | transfer out
//   cfg     | cfg_valid_i/cfg_ready_o, index, data      | register write
//
// An in-range add rotates the whole chain once through the merge unit, whether it merges,
// appends or finds the queue full.
// Remove, clear, the spare code and out-of-range adds go from idle straight to the done state.
// The result sits in an output register; the next transfer is taken while it waits,
// and that item holds in its last cycle until the register is free.
// Reset empties the queue and loads the default register values.
`default_nettype none
module coalescing_event_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          func_i,
  input  logic [ceq_pkg::TypeW-1:0]           event_type_i,
  input  logic signed [ceq_pkg::ValueW-1:0]   event_value_i,
  input  logic                                eligible_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                accepted_o,
  output logic                                head_valid_o,
  output logic [ceq_pkg::TypeW-1:0]           head_type_o,
  output logic signed [ceq_pkg::ValueW-1:0]   head_value_o,
  output logic                                head_eligible_o,
  output logic [ceq_pkg::CountW-1:0]          entry_count_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ceq_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [ceq_pkg::CfgDataW-1:0]        cfg_data_i
);
  import ceq_pkg::*;

  state_e      state_q, state_d;
  logic [CountW-1:0] fill_q, fill_d;
  logic [CountW-1:0] step_q, step_d;
  logic        found_q, found_d;
  logic        shift;
  entry_t      feed;
  entry_t      cells [QueueDepth];
  entry_t      op_q, op_d;
  merge_mode_e mode_q, mode_d;
  merge_mode_e mode_new;
  logic signed [ValueW-1:0] merged;
  logic        hit, app;

  logic [8:0]       type_count_q;
  logic [8:0]       max_limit_q;
  logic [TypeW-1:0] floor_type_q;
  logic [TypeW-1:0] seed_type_q;
  logic [TypeW-1:0] accum_type_q;

  logic                     out_valid_q;
  logic                     accepted_q;
  logic                     head_valid_q;
  logic [TypeW-1:0]         head_type_q;
  logic signed [ValueW-1:0] head_value_q;
  logic                     head_eligible_q;
  logic [CountW-1:0]        entry_count_q;
  logic                     load_out;

  genvar gi;
  generate
    for (gi = 0; gi < QueueDepth; gi++) begin : g_cell
      if (gi == QueueDepth - 1) begin : g_last
        ceq_cell u_cell (.clk_i(clk_i), .shift_i(shift), .next_i(feed),
                         .entry_o(cells[gi]));
      end else begin : g_mid
        ceq_cell u_cell (.clk_i(clk_i), .shift_i(shift), .next_i(cells[gi+1]),
                         .entry_o(cells[gi]));
      end
    end
  endgenerate

  ceq_merge u_merge (
    .mode_i    (mode_q),
    .stored_i  (cells[0].value),
    .incoming_i(op_q.value),
    .merged_o  (merged)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_count_q <= 9'd32;
      max_limit_q  <= 9'd12;
      floor_type_q <= 8'd12;
      seed_type_q  <= 8'd13;
      accum_type_q <= 8'd14;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TYPE_COUNT: type_count_q <= cfg_data_i;
        CFG_MAX_LIMIT:  max_limit_q  <= cfg_data_i;
        CFG_FLOOR_TYPE: floor_type_q <= cfg_data_i[TypeW-1:0];
        CFG_SEED_TYPE:  seed_type_q  <= cfg_data_i[TypeW-1:0];
        CFG_ACCUM_TYPE: accum_type_q <= cfg_data_i[TypeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if ({1'b0, event_type_i} < max_limit_q || event_type_i == floor_type_q) begin
      mode_new = MERGE_MAX;
    end else if (event_type_i == seed_type_q) begin
      mode_new = MERGE_SEED;
    end else if (event_type_i == accum_type_q) begin
      mode_new = MERGE_ACC;
    end else begin
      mode_new = MERGE_KEEP;
    end
  end

  assign hit = (step_q < fill_q) && (cells[0].etype == op_q.etype) && !found_q;
  assign app = (step_q == fill_q) && !found_q;

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    step_d     = step_q;
    found_d    = found_q;
    op_d       = op_q;
    mode_d     = mode_q;
    shift      = 1'b0;
    feed       = cells[0];
    in_ready_o = (state_q == ST_IDLE);
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DONE;
          found_d = 1'b0;
          unique case (func_e'(func_i))
            FUNC_ADD: begin
              op_d   = '{etype: event_type_i, value: event_value_i, flag: eligible_in_i};
              mode_d = mode_new;
              step_d = '0;
              if ({1'b0, event_type_i} < type_count_q) begin
                state_d = ST_WALK;
              end
            end
            FUNC_REMOVE: begin
              if (fill_q != '0) begin
                shift  = 1'b1;
                fill_d = fill_q - CountW'(1);
              end
            end
            FUNC_CLEAR: fill_d = '0;
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        shift  = 1'b1;
        step_d = step_q + CountW'(1);
        if (hit) begin
          feed.value = merged;
          feed.flag  = cells[0].flag | op_q.flag;
          found_d    = 1'b1;
        end else if (app) begin
          feed    = op_q;
          found_d = 1'b1;
          fill_d  = fill_q + CountW'(1);
        end
        if (step_q == CountW'(QueueDepth - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      step_q  <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      step_q  <= step_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    mode_q <= mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      accepted_q      <= found_q;
      head_valid_q    <= (fill_q != '0);
      head_type_q     <= (fill_q != '0) ? cells[0].etype : '0;
      head_value_q    <= (fill_q != '0) ? cells[0].value : '0;
      head_eligible_q <= (fill_q != '0) ? cells[0].flag : 1'b0;
      entry_count_q   <= fill_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = accepted_q;
  assign head_valid_o    = head_valid_q;
  assign head_type_o     = head_type_q;
  assign head_value_o    = head_value_q;
  assign head_eligible_o = head_eligible_q;
  assign entry_count_o   = entry_count_q;

endmodule
`default_nettype wire
